/* src/dsbb_pkg.sv */
// ----------------------------------------------------------------------------
// dsbb_pkg: shared constants and types for the billboard depth sorter
// Field widths, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package dsbb_pkg;

	localparam int MAX_INST_DEF = 32;

	localparam int COORD_W   = 16;
	localparam int SLOT_W    = 5;
	localparam int VEC_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z = 2'd2;

	localparam int MAG_W  = 16;
	localparam int SQ_W   = 32;
	localparam int H2_W   = 33;
	localparam int L2_W   = 34;
	localparam int M2_W   = 64;
	localparam int DUP_W  = 67;
	localparam int MOP_W  = 34;
	localparam int PROD_W = 68;
	localparam int ACC_W  = 100;
	localparam int T_W    = 16;
	localparam int Q_W    = 15;
	localparam int NCOMP  = 8;
	localparam int FRAC_SH = 30;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [VEC_W-1:0]   vec_t;

endpackage

/* src/dsbb_item_if.sv */
// ----------------------------------------------------------------------------
// dsbb_item_if: instance position channel
// Valid/ready channel carrying one instance position and the batch mark.
// ----------------------------------------------------------------------------
interface dsbb_item_if import dsbb_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t inst_x;
	coord_t inst_y;
	coord_t inst_z;
	logic   final_item;

	modport source (output valid, output inst_x, output inst_y, output inst_z,
		output final_item, input ready);
	modport sink (input valid, input inst_x, input inst_y, input inst_z,
		input final_item, output ready);
endinterface

/* src/dsbb_result_if.sv */
// ----------------------------------------------------------------------------
// dsbb_result_if: sorted billboard basis channel
// Valid/ready channel carrying one slot with its right, up and forward vectors.
// ----------------------------------------------------------------------------
interface dsbb_result_if import dsbb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot;
	vec_t              right_x;
	vec_t              right_z;
	vec_t              up_x;
	vec_t              up_y;
	vec_t              up_z;
	vec_t              fwd_x;
	vec_t              fwd_y;
	vec_t              fwd_z;
	logic              batch_end;

	modport source (output valid, output slot, output right_x, output right_z,
		output up_x, output up_y, output up_z, output fwd_x, output fwd_y,
		output fwd_z, output batch_end, input ready);
	modport sink (input valid, input slot, input right_x, input right_z,
		input up_x, input up_y, input up_z, input fwd_x, input fwd_y,
		input fwd_z, input batch_end, output ready);
endinterface

/* src/depth_sort_billboard_basis.sv */
// ----------------------------------------------------------------------------
// depth_sort_billboard_basis: back-to-front sorter with billboard basis
// Loads positions one per cycle, sorts by camera distance, emits unit vectors.
// ----------------------------------------------------------------------------
// Loads: one transfer per cycle. After the final item, keys are computed per
// instance, then ranked (one stored key read per cycle); each result then takes
// the 8 normalizations of 16 steps each in one shared add-compare unit. Reset
// clears control, count and camera registers; the position and order memories
// are not cleared.
module depth_sort_billboard_basis import dsbb_pkg::*; #(
	parameter int MAX_INSTANCES = MAX_INST_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	dsbb_item_if.sink            items,
	dsbb_result_if.source        results
);

	localparam int IW    = $clog2(MAX_INSTANCES);
	localparam int CW    = $clog2(MAX_INSTANCES + 1);
	localparam int SW    = (IW > SLOT_W) ? IW : SLOT_W;
	localparam int MEM_W = 3 * COORD_W + L2_W;

	typedef enum logic [13:0] {
		S_LOAD = 14'b00000000000001,
		S_KRD  = 14'b00000000000010,
		S_DIF  = 14'b00000000000100,
		S_MUL  = 14'b00000000001000,
		S_KWR  = 14'b00000000010000,
		S_RRD  = 14'b00000000100000,
		S_RKEY = 14'b00000001000000,
		S_RCMP = 14'b00000010000000,
		S_RWR  = 14'b00000100000000,
		S_ORD  = 14'b00001000000000,
		S_OPOS = 14'b00010000000000,
		S_NSET = 14'b00100000000000,
		S_NSTP = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q;
	coord_t cam_x_q, cam_y_q, cam_z_q;
	logic [CW-1:0] cnt_q, n_q, i_q, j_q, r_q, rank_q;
	logic          emit_q;
	logic [2:0]    mcnt_q, c_q;
	logic [3:0]    b_q;

	logic [MAG_W-1:0]  ax_q, ay_q, az_q;
	logic              dxn_q, dyn_q, dzn_q, dx0_q, dy0_q, dz0_q;
	logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q, pxy_q, pzy_q;
	logic [M2_W-1:0]   m2xy_q, m2zy_q;
	logic [DUP_W-1:0]  dup_q;
	logic [L2_W-1:0]   key_i_q;
	logic [IW-1:0]     slot_q;
	logic [ACC_W-1:0]  nn_q, sq_q, aa_q, bb_q;
	logic [T_W-1:0]    t_q;
	logic              zero_q;
	logic [Q_W-1:0]    q_q [NCOMP];

	logic [MEM_W-1:0] pos_mem [MAX_INSTANCES];
	logic [MEM_W-1:0] pos_rd_q;
	logic [IW-1:0]    ord_mem [MAX_INSTANCES];
	logic [IW-1:0]    ord_rd_q;

	logic             pos_re, pos_we, ord_re, ord_we;
	logic [IW-1:0]    pos_raddr, pos_waddr, ord_raddr, ord_waddr, ord_wdata;
	logic [MEM_W-1:0] pos_wdata;

	logic in_xfer, out_xfer, has_room;
	logic [CW-1:0] i_inc, j_inc, r_inc, rank_next;
	logic [H2_W-1:0] h2;
	logic [L2_W-1:0] l2;
	coord_t rd_px, rd_py, rd_pz;
	logic [L2_W-1:0] rd_key;
	logic signed [COORD_W:0] dx, dy, dz;
	logic [COORD_W:0] mx, my, mz;
	logic [MOP_W-1:0] opa, opb;
	logic [PROD_W-1:0] prod;
	logic [M2_W-1:0] nbase;
	logic [DUP_W-1:0] dbase;
	logic [ACC_W-1:0] cand;
	logic ok, key_gt;
	logic [T_W-1:0] t_next;
	logic [T_W:0] t_rnd;
	logic [SW-1:0] slot_ext;

	assign in_xfer  = items.valid & items.ready;
	assign out_xfer = results.valid & results.ready;
	assign has_room = cnt_q < CW'(MAX_INSTANCES);
	assign i_inc = i_q + 1'b1;
	assign j_inc = j_q + 1'b1;
	assign r_inc = r_q + 1'b1;

	assign h2 = {1'b0, sqx_q} + {1'b0, sqz_q};
	assign l2 = {1'b0, h2} + {2'b0, sqy_q};

	assign rd_px  = pos_rd_q[MEM_W-1 -: COORD_W];
	assign rd_py  = pos_rd_q[MEM_W-COORD_W-1 -: COORD_W];
	assign rd_pz  = pos_rd_q[MEM_W-2*COORD_W-1 -: COORD_W];
	assign rd_key = pos_rd_q[L2_W-1:0];

	assign dx = {cam_x_q[COORD_W-1], cam_x_q} - {rd_px[COORD_W-1], rd_px};
	assign dy = {cam_y_q[COORD_W-1], cam_y_q} - {rd_py[COORD_W-1], rd_py};
	assign dz = {cam_z_q[COORD_W-1], cam_z_q} - {rd_pz[COORD_W-1], rd_pz};
	assign mx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
	assign my = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
	assign mz = dz[COORD_W] ? (COORD_W+1)'(-dz) : dz;

	assign key_gt = (rd_key > key_i_q) || ((rd_key == key_i_q) && (j_q < i_q));
	assign rank_next = rank_q + CW'(key_gt);

	always_comb begin
		case (mcnt_q)
			3'd0: begin opa = MOP_W'(ax_q);   opb = MOP_W'(ax_q);  end
			3'd1: begin opa = MOP_W'(ay_q);   opb = MOP_W'(ay_q);  end
			3'd2: begin opa = MOP_W'(az_q);   opb = MOP_W'(az_q);  end
			3'd3: begin opa = MOP_W'(ax_q);   opb = MOP_W'(ay_q);  end
			3'd4: begin opa = MOP_W'(az_q);   opb = MOP_W'(ay_q);  end
			3'd5: begin opa = MOP_W'(pxy_q);  opb = MOP_W'(pxy_q); end
			3'd6: begin opa = MOP_W'(pzy_q);  opb = MOP_W'(pzy_q); end
			default: begin opa = MOP_W'(h2); opb = l2; end
		endcase
	end
	assign prod = opa * opb;

	always_comb begin
		case (c_q)
			3'd0: begin nbase = M2_W'(sqz_q);  dbase = DUP_W'(h2);  end
			3'd1: begin nbase = M2_W'(sqx_q);  dbase = DUP_W'(h2);  end
			3'd2: begin nbase = m2xy_q;        dbase = dup_q;       end
			3'd3: begin nbase = M2_W'(h2);     dbase = DUP_W'(l2);  end
			3'd4: begin nbase = m2zy_q;        dbase = dup_q;       end
			3'd5: begin nbase = M2_W'(sqx_q);  dbase = DUP_W'(l2);  end
			3'd6: begin nbase = M2_W'(sqy_q);  dbase = DUP_W'(l2);  end
			default: begin nbase = M2_W'(sqz_q); dbase = DUP_W'(l2); end
		endcase
	end

	assign cand   = sq_q + aa_q + bb_q;
	assign ok     = cand <= nn_q;
	assign t_next = ok ? (t_q | (T_W'(1) << b_q)) : t_q;
	assign t_rnd  = {1'b0, t_next} + 1'b1;

	always_comb begin
		pos_re = 1'b0; pos_raddr = i_q[IW-1:0];
		pos_we = 1'b0; pos_waddr = i_q[IW-1:0];
		pos_wdata = {pos_rd_q[MEM_W-1:L2_W], l2};
		ord_re = 1'b0; ord_raddr = r_q[IW-1:0];
		ord_we = 1'b0; ord_waddr = rank_q[IW-1:0]; ord_wdata = i_q[IW-1:0];
		case (state_q)
			S_LOAD: begin
				pos_we = in_xfer & has_room;
				pos_waddr = cnt_q[IW-1:0];
				pos_wdata = {items.inst_x, items.inst_y, items.inst_z, L2_W'(0)};
			end
			S_KRD: pos_re = 1'b1;
			S_KWR: pos_we = 1'b1;
			S_RRD: pos_re = 1'b1;
			S_RKEY: begin
				pos_re = 1'b1;
				pos_raddr = '0;
			end
			S_RCMP: begin
				pos_re = (j_inc != n_q);
				pos_raddr = j_inc[IW-1:0];
			end
			S_RWR: ord_we = 1'b1;
			S_ORD: ord_re = 1'b1;
			S_OPOS: begin
				pos_re = 1'b1;
				pos_raddr = ord_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
		if (pos_re) pos_rd_q <= pos_mem[pos_raddr];
		if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
		if (ord_re) ord_rd_q <= ord_mem[ord_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAM_X: cam_x_q <= cfg_data;
				CFG_CAM_Y: cam_y_q <= cfg_data;
				CFG_CAM_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			r_q <= '0;
			rank_q <= '0;
			emit_q <= 1'b0;
			mcnt_q <= '0;
			c_q <= '0;
			b_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (has_room) cnt_q <= cnt_q + 1'b1;
						if (items.final_item) begin
							n_q <= has_room ? cnt_q + 1'b1 : cnt_q;
							i_q <= '0;
							emit_q <= 1'b0;
							state_q <= S_KRD;
						end
					end
				end
				S_KRD: state_q <= S_DIF;
				S_DIF: begin
					mcnt_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (!emit_q && mcnt_q == 3'd2) begin
						state_q <= S_KWR;
					end else if (emit_q && mcnt_q == 3'd7) begin
						c_q <= '0;
						state_q <= S_NSET;
					end
				end
				S_KWR: begin
					if (i_inc == n_q) begin
						i_q <= '0;
						state_q <= S_RRD;
					end else begin
						i_q <= i_inc;
						state_q <= S_KRD;
					end
				end
				S_RRD: state_q <= S_RKEY;
				S_RKEY: begin
					j_q <= '0;
					rank_q <= '0;
					state_q <= S_RCMP;
				end
				S_RCMP: begin
					rank_q <= rank_next;
					if (j_inc == n_q) state_q <= S_RWR;
					else j_q <= j_inc;
				end
				S_RWR: begin
					if (i_inc == n_q) begin
						r_q <= '0;
						emit_q <= 1'b1;
						state_q <= S_ORD;
					end else begin
						i_q <= i_inc;
						state_q <= S_RRD;
					end
				end
				S_ORD: state_q <= S_OPOS;
				S_OPOS: state_q <= S_DIF;
				S_NSET: begin
					b_q <= 4'd15;
					state_q <= S_NSTP;
				end
				S_NSTP: begin
					b_q <= b_q - 1'b1;
					if (b_q == 4'd0) begin
						if (c_q == 3'(NCOMP - 1)) begin
							state_q <= S_OUT;
						end else begin
							c_q <= c_q + 1'b1;
							state_q <= S_NSET;
						end
					end
				end
				S_OUT: begin
					if (out_xfer) begin
						if (r_inc == n_q) begin
							cnt_q <= '0;
							state_q <= S_LOAD;
						end else begin
							r_q <= r_inc;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_RKEY: key_i_q <= rd_key;
			S_OPOS: slot_q <= ord_rd_q;
			S_DIF: begin
				ax_q <= mx[MAG_W-1:0];
				ay_q <= my[MAG_W-1:0];
				az_q <= mz[MAG_W-1:0];
				dxn_q <= dx[COORD_W];
				dyn_q <= dy[COORD_W];
				dzn_q <= dz[COORD_W];
				dx0_q <= (dx == '0);
				dy0_q <= (dy == '0);
				dz0_q <= (dz == '0);
			end
			S_MUL: begin
				case (mcnt_q)
					3'd0: sqx_q <= prod[SQ_W-1:0];
					3'd1: sqy_q <= prod[SQ_W-1:0];
					3'd2: sqz_q <= prod[SQ_W-1:0];
					3'd3: pxy_q <= prod[SQ_W-1:0];
					3'd4: pzy_q <= prod[SQ_W-1:0];
					3'd5: m2xy_q <= prod[M2_W-1:0];
					3'd6: m2zy_q <= prod[M2_W-1:0];
					default: dup_q <= prod[DUP_W-1:0];
				endcase
			end
			S_NSET: begin
				nn_q <= ACC_W'(nbase) << FRAC_SH;
				bb_q <= ACC_W'(dbase) << FRAC_SH;
				aa_q <= '0;
				sq_q <= '0;
				t_q <= '0;
				zero_q <= (nbase == '0) || (dbase == '0);
			end
			S_NSTP: begin
				if (ok) begin
					sq_q <= cand;
					aa_q <= (aa_q >> 1) + bb_q;
				end else begin
					aa_q <= aa_q >> 1;
				end
				bb_q <= bb_q >> 2;
				t_q <= t_next;
				if (b_q == 4'd0) q_q[c_q] <= zero_q ? '0 : t_rnd[Q_W:1];
			end
			default: ;
		endcase
	end

	function automatic vec_t apply_sign(input logic neg, input logic [Q_W-1:0] q);
		vec_t v;
		v = vec_t'({1'b0, q});
		return neg ? -v : v;
	endfunction

	assign slot_ext = SW'(slot_q);

	assign items.ready       = (state_q == S_LOAD);
	assign results.valid     = (state_q == S_OUT);
	assign results.slot      = slot_ext[SLOT_W-1:0];
	assign results.right_x   = apply_sign(dzn_q, q_q[0]);
	assign results.right_z   = apply_sign(!dxn_q && !dx0_q, q_q[1]);
	assign results.up_x      = apply_sign((dxn_q == dyn_q) && !dx0_q && !dy0_q, q_q[2]);
	assign results.up_y      = apply_sign(1'b0, q_q[3]);
	assign results.up_z      = apply_sign((dzn_q == dyn_q) && !dz0_q && !dy0_q, q_q[4]);
	assign results.fwd_x     = apply_sign(dxn_q, q_q[5]);
	assign results.fwd_y     = apply_sign(dyn_q, q_q[6]);
	assign results.fwd_z     = apply_sign(dzn_q, q_q[7]);
	assign results.batch_end = (r_inc == n_q);

endmodule
